>>> hw/rtl/clcd_pkg.sv
// ----------------------------------------------------------------------------
// Character LCD write sequencer package
// Shared types, register indexes and byte constants for the LCD bus sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

   // Default depth of the request queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Configuration port widths.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_FOUR_BIT_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FUNCTION_SET  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_ON    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLEAR         = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_DELAY   = 3'd4;

   // Register reset values.
   localparam logic [7:0] RST_FUNCTION_SET = 8'h38;
   localparam logic [7:0] RST_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] RST_CLEAR        = 8'h01;
   localparam logic [9:0] RST_PHASE_DELAY  = 10'd30;

   // Fixed bytes of the init sequence and the set-address command bit.
   localparam logic [7:0] INIT_WAKE_BYTE  = 8'h33;
   localparam logic [7:0] INIT_NIBBLE_BYTE = 8'h32;
   localparam logic [7:0] ADDR_SET_BIT    = 8'h80;

   // Init byte slots; 8-bit mode starts at the function set byte.
   localparam logic [2:0] INIT_FIRST_4BIT = 3'd0;
   localparam logic [2:0] INIT_FIRST_8BIT = 3'd2;
   localparam logic [2:0] INIT_LAST       = 3'd4;

   // Final phase number of one byte.
   localparam logic [2:0] LAST_PHASE_4BIT = 3'd4;
   localparam logic [2:0] LAST_PHASE_8BIT = 3'd3;

   // Request action codes.
   typedef enum logic [1:0] {
      ACT_COMMAND = 2'd0,
      ACT_DATA    = 2'd1,
      ACT_CURSOR  = 2'd2,
      ACT_INIT    = 2'd3
   } action_type;

   // Configuration registers as seen by the back end.
   typedef struct packed {
      logic       four_bit_mode;
      logic [7:0] function_set_command;
      logic [7:0] display_on_command;
      logic [7:0] clear_command;
      logic [9:0] phase_delay_ms;
   } cfg_type;

   // One classified request waiting for the back end.
   typedef struct packed {
      logic       init;
      logic       rs;
      logic [7:0] value;
   } job_type;

   // DDRAM start offset of each display row.
   function automatic logic [7:0] row_offset(input logic [1:0] row);
      logic [7:0] offset;
      case (row)
         2'd0:    offset = 8'h00;
         2'd1:    offset = 8'h40;
         2'd2:    offset = 8'h10;
         2'd3:    offset = 8'h50;
         default: offset = 8'h00;
      endcase
      return offset;
   endfunction

endpackage

>>> hw/rtl/char_lcd_write_sequencer_core.sv
// ----------------------------------------------------------------------------
// Character LCD write sequencer
// Turns command, data, cursor and init requests into timed LCD pin phases.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  req_    | in        | req_valid/req_stall | action, byte_value, row, column
//  rsp_    | out       | rsp_valid/rsp_stall | reg_select, read_write, enable,
//          |           |                     | data_pins, hold_ms, last
//  csr_    | in        | csr_valid/csr_ready | index, data
//
// The phase sequencer emits one pin phase per cycle unless rsp_ stalls; a byte
// is 4 phases in 8-bit mode, 5 in 4-bit mode; an init request is 3 or 5 bytes.
// A request is classified on entry and held in a two-entry queue, so new
// requests are taken while earlier ones are still being sequenced.
// Reset is synchronous; it clears the queue, the sequencer and the pin levels.
// A stall on rsp_ holds the output register and the sequencer in place.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_core #(
   parameter int QueueDepth = clcd_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_action,
   input  logic [7:0]                       req_byte_value,
   input  logic [1:0]                       req_row,
   input  logic [5:0]                       req_column,
   // Result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_reg_select,
   output logic                             rsp_read_write,
   output logic                             rsp_enable,
   output logic [7:0]                       rsp_data_pins,
   output logic [9:0]                       rsp_hold_ms,
   output logic                             rsp_last,
   // Configuration channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [clcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [clcd_pkg::CSR_DATA_W-1:0]  csr_data
);
   import clcd_pkg::*;

   cfg_type cfg;
   job_type front_job;
   job_type head;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   logic    q_push;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   clcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   clcd_front u_front (
      .req_action     (req_action),
      .req_byte_value (req_byte_value),
      .req_row        (req_row),
      .req_column     (req_column),
      .job            (front_job)
   );

   // A request enters the queue whenever there is room.
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   clcd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (front_job),
      .full     (q_full),
      .pop      (q_pop),
      .head     (head),
      .empty    (q_empty)
   );

   clcd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .head           (head),
      .empty          (q_empty),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reg_select (rsp_reg_select),
      .rsp_enable     (rsp_enable),
      .rsp_data_pins  (rsp_data_pins),
      .rsp_hold_ms    (rsp_hold_ms),
      .rsp_last       (rsp_last)
   );

   // The bus is only ever written.
   assign rsp_read_write = 1'b0;

endmodule

>>> hw/rtl/clcd_csr.sv
// ----------------------------------------------------------------------------
// Character LCD configuration registers
// Holds the mode, init bytes and phase hold time written over the CSR port.
// ----------------------------------------------------------------------------
module clcd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [clcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [clcd_pkg::CSR_DATA_W-1:0]  csr_data,
   output clcd_pkg::cfg_type               cfg
);
   import clcd_pkg::*;

   cfg_type cfg_ff;

   // Register write decode.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.four_bit_mode        <= 1'b0;
         cfg_ff.function_set_command <= RST_FUNCTION_SET;
         cfg_ff.display_on_command   <= RST_DISPLAY_ON;
         cfg_ff.clear_command        <= RST_CLEAR;
         cfg_ff.phase_delay_ms       <= RST_PHASE_DELAY;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FOUR_BIT_MODE: cfg_ff.four_bit_mode        <= csr_data[0];
            CSR_FUNCTION_SET:  cfg_ff.function_set_command <= csr_data[7:0];
            CSR_DISPLAY_ON:    cfg_ff.display_on_command   <= csr_data[7:0];
            CSR_CLEAR:         cfg_ff.clear_command        <= csr_data[7:0];
            CSR_PHASE_DELAY:   cfg_ff.phase_delay_ms       <= csr_data[9:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/clcd_front.sv
// ----------------------------------------------------------------------------
// Character LCD request front end
// Classifies each request into a byte job: command, data, address or init.
// ----------------------------------------------------------------------------
module clcd_front (
   input  logic [1:0]         req_action,
   input  logic [7:0]         req_byte_value,
   input  logic [1:0]         req_row,
   input  logic [5:0]         req_column,
   output clcd_pkg::job_type  job
);
   import clcd_pkg::*;

   logic [7:0] cursor_addr;

   // Set-address command for a cursor move.
   assign cursor_addr = ({2'b00, req_column} + row_offset(req_row)) | ADDR_SET_BIT;

   // Classify the request.
   always_comb begin
      job.init  = 1'b0;
      job.rs    = 1'b0;
      job.value = req_byte_value;
      case (action_type'(req_action))
         ACT_COMMAND: begin
            job.rs = 1'b0;
         end
         ACT_DATA: begin
            job.rs = 1'b1;
         end
         ACT_CURSOR: begin
            job.value = cursor_addr;
         end
         ACT_INIT: begin
            job.init = 1'b1;
         end
         default: begin
            job.init = 1'b1;
         end
      endcase
   end

endmodule

>>> hw/rtl/clcd_queue.sv
// ----------------------------------------------------------------------------
// Character LCD job queue
// Short FIFO of classified jobs between the front end and the phase sequencer.
// ----------------------------------------------------------------------------
module clcd_queue #(
   parameter int Depth = clcd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  clcd_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output clcd_pkg::job_type head,
   output logic              empty
);
   import clcd_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   job_type         slots_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [PtrW-1:0] rd_ptr_in;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;

   assign full  = (count_ff == CntFull);
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> hw/rtl/clcd_back.sv
// ----------------------------------------------------------------------------
// Character LCD phase sequencer
// Expands each job into bytes and each byte into timed pin phases.
// ----------------------------------------------------------------------------
module clcd_back (
   input  logic              clock,
   input  logic              reset,
   input  clcd_pkg::cfg_type cfg,
   input  clcd_pkg::job_type head,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_reg_select,
   output logic              rsp_enable,
   output logic [7:0]        rsp_data_pins,
   output logic [9:0]        rsp_hold_ms,
   output logic              rsp_last
);
   import clcd_pkg::*;

   // Sequencer state.
   logic       busy_ff, busy_in;
   job_type    job_ff, job_in;
   logic [2:0] phase_ff, phase_in;
   logic [2:0] byte_ff, byte_in;

   // Pin levels last driven.
   logic       rs_level_ff, rs_level_in;
   logic       enable_level_ff, enable_level_in;
   logic [7:0] data_level_ff, data_level_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_last_ff, rsp_last_in;
   logic [9:0] rsp_hold_ff, rsp_hold_in;

   logic       out_free;
   logic       step;
   job_type    cur_job;
   logic [2:0] cur_phase;
   logic [2:0] cur_byte;
   logic [7:0] cur_value;
   logic       final_phase;
   logic       final_byte;

   // The output slot can take a phase when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign step     = out_free && (busy_ff || !empty);
   assign pop      = step && !busy_ff;

   // Current job, byte and phase; a new job starts straight from the queue head.
   assign cur_job   = busy_ff ? job_ff : head;
   assign cur_phase = busy_ff ? phase_ff : 3'd0;
   assign cur_byte  = busy_ff ? byte_ff
                              : (cfg.four_bit_mode ? INIT_FIRST_4BIT : INIT_FIRST_8BIT);

   // Byte being sent.
   always_comb begin
      cur_value = cur_job.value;
      if (cur_job.init) begin
         case (cur_byte)
            3'd0:    cur_value = INIT_WAKE_BYTE;
            3'd1:    cur_value = INIT_NIBBLE_BYTE;
            3'd2:    cur_value = cfg.function_set_command;
            3'd3:    cur_value = cfg.display_on_command;
            default: cur_value = cfg.clear_command;
         endcase
      end
   end

   assign final_phase = cfg.four_bit_mode ? (cur_phase == LAST_PHASE_4BIT)
                                          : (cur_phase == LAST_PHASE_8BIT);
   assign final_byte  = !cur_job.init || (cur_byte == INIT_LAST);

   // Pin levels of the phase being emitted.
   always_comb begin
      rs_level_in     = rs_level_ff;
      enable_level_in = enable_level_ff;
      data_level_in   = data_level_ff;
      if (step) begin
         case (cur_phase)
            3'd0: begin
               rs_level_in = cur_job.rs;
            end
            3'd1: begin
               enable_level_in = 1'b1;
               if (cfg.four_bit_mode) begin
                  data_level_in = {4'h0, cur_value[7:4]};
               end
            end
            3'd2: begin
               if (cfg.four_bit_mode) begin
                  enable_level_in = 1'b0;
               end else begin
                  data_level_in = cur_value;
               end
            end
            3'd3: begin
               if (cfg.four_bit_mode) begin
                  enable_level_in = 1'b1;
                  data_level_in   = {4'h0, cur_value[3:0]};
               end else begin
                  enable_level_in = 1'b0;
               end
            end
            default: begin
               enable_level_in = 1'b0;
            end
         endcase
      end
   end

   // Phase, byte and job advance.
   always_comb begin
      busy_in  = busy_ff;
      job_in   = job_ff;
      phase_in = phase_ff;
      byte_in  = byte_ff;
      if (step) begin
         job_in = cur_job;
         if (final_phase) begin
            phase_in = 3'd0;
            byte_in  = cur_byte + 1'b1;
            busy_in  = !final_byte;
         end else begin
            phase_in = cur_phase + 1'b1;
            byte_in  = cur_byte;
            busy_in  = 1'b1;
         end
      end
   end

   // Output register loading.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_hold_in  = rsp_hold_ff;
      if (out_free) begin
         rsp_valid_in = step;
         rsp_last_in  = final_phase && final_byte;
         rsp_hold_in  = cfg.phase_delay_ms;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         phase_ff        <= 3'd0;
         byte_ff         <= 3'd0;
         rs_level_ff     <= 1'b0;
         enable_level_ff <= 1'b0;
         data_level_ff   <= 8'h00;
         rsp_valid_ff    <= 1'b0;
      end else begin
         busy_ff         <= busy_in;
         phase_ff        <= phase_in;
         byte_ff         <= byte_in;
         rs_level_ff     <= rs_level_in;
         enable_level_ff <= enable_level_in;
         data_level_ff   <= data_level_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      rsp_last_ff <= rsp_last_in;
      rsp_hold_ff <= rsp_hold_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_select = rs_level_ff;
   assign rsp_enable     = enable_level_ff;
   assign rsp_data_pins  = data_level_ff;
   assign rsp_hold_ms    = rsp_hold_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

>>> bench/tb_char_lcd_write_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD write sequencer testbench
// Sends command, data, cursor and init requests under several register
// settings, with random idling on both channels and one long receiver
// hold-off. Every pin phase is predicted in the bench and each phase that
// leaves the block is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_char_lcd_write_sequencer_core;
   import clcd_pkg::*;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 40;
   localparam int RANDOM_ROUNDS   = 6;
   localparam int ROUND_REQUESTS  = 55;

   // One pin phase as it appears on the result channel.
   typedef struct packed {
      logic       reg_select;
      logic       read_write;
      logic       enable;
      logic [7:0] data_pins;
      logic [9:0] hold_ms;
      logic       last;
   } pin_phase_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   action_type             req_action     = ACT_COMMAND;
   logic [7:0]             req_byte_value = 8'h00;
   logic [1:0]             req_row        = 2'd0;
   logic [5:0]             req_column     = 6'd0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic                   rsp_reg_select;
   logic                   rsp_read_write;
   logic                   rsp_enable;
   logic [7:0]             rsp_data_pins;
   logic [9:0]             rsp_hold_ms;
   logic                   rsp_last;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = CSR_FOUR_BIT_MODE;
   logic [CSR_DATA_W-1:0]  csr_data       = '0;

   // Predicted bus levels and register settings.
   cfg_type       lcd_cfg;
   logic          bus_rs;
   logic          bus_enable;
   logic [7:0]    bus_data;
   pin_phase_type pending_phases[$];

   int mismatch_count = 0;
   int stall_left     = 0;
   bit hold_off_go    = 1'b0;
   bit gaps_on        = 1'b1;
   bit valid_held     = 1'b0;

   char_lcd_write_sequencer_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_byte_value (req_byte_value),
      .req_row        (req_row),
      .req_column     (req_column),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reg_select (rsp_reg_select),
      .rsp_read_write (rsp_read_write),
      .rsp_enable     (rsp_enable),
      .rsp_data_pins  (rsp_data_pins),
      .rsp_hold_ms    (rsp_hold_ms),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #5 clock = ~clock;

   // Idle length: mostly from the shortest range, sometimes the middle one, rarely the longest.
   function automatic int pick_idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return $urandom_range(1, 2);
      end else if (r < 95) begin
         return $urandom_range(3, 8);
      end
      return $urandom_range(15, 40);
   endfunction

   // Record the current bus levels as the next predicted phase.
   function automatic void queue_pin_phase();
      pin_phase_type ph;
      ph.reg_select = bus_rs;
      ph.read_write = 1'b0;
      ph.enable     = bus_enable;
      ph.data_pins  = bus_data;
      ph.hold_ms    = lcd_cfg.phase_delay_ms;
      ph.last       = 1'b0;
      pending_phases.push_back(ph);
   endfunction

   // Expand one byte into its pin phases, whole byte or two nibbles.
   function automatic void expand_byte(input logic rs, input logic [7:0] value);
      bus_rs = rs;
      queue_pin_phase();
      if (lcd_cfg.four_bit_mode) begin
         bus_data   = {4'h0, value[7:4]};
         bus_enable = 1'b1;
         queue_pin_phase();
         bus_enable = 1'b0;
         queue_pin_phase();
         bus_data   = {4'h0, value[3:0]};
         bus_enable = 1'b1;
         queue_pin_phase();
         bus_enable = 1'b0;
         queue_pin_phase();
      end else begin
         bus_enable = 1'b1;
         queue_pin_phase();
         bus_data = value;
         queue_pin_phase();
         bus_enable = 1'b0;
         queue_pin_phase();
      end
   endfunction

   // Predict every phase of one accepted request and mark its final phase.
   function automatic void expand_request(input action_type act, input logic [7:0] value,
                                          input logic [1:0] row, input logic [5:0] column);
      logic [7:0] offset;
      case (act)
         ACT_COMMAND: begin
            expand_byte(1'b0, value);
         end
         ACT_DATA: begin
            expand_byte(1'b1, value);
         end
         ACT_CURSOR: begin
            // Rows start at DDRAM offsets 0x00, 0x40, 0x10 and 0x50.
            case (row)
               2'd0:    offset = 8'h00;
               2'd1:    offset = 8'h40;
               2'd2:    offset = 8'h10;
               default: offset = 8'h50;
            endcase
            expand_byte(1'b0, ({2'b00, column} + offset) | ADDR_SET_BIT);
         end
         default: begin
            // The wake-up bytes are only sent when the bus runs in nibbles.
            if (lcd_cfg.four_bit_mode) begin
               expand_byte(1'b0, INIT_WAKE_BYTE);
               expand_byte(1'b0, INIT_NIBBLE_BYTE);
            end
            expand_byte(1'b0, lcd_cfg.function_set_command);
            expand_byte(1'b0, lcd_cfg.display_on_command);
            expand_byte(1'b0, lcd_cfg.clear_command);
         end
      endcase
      pending_phases[pending_phases.size() - 1].last = 1'b1;
   endfunction

   task automatic flag_mismatch(input string what, input logic [9:0] got,
                                input logic [9:0] want);
      $display("MISMATCH %s: got %0h, predicted %0h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   // Check each phase that leaves the block against the oldest prediction.
   always @(posedge clock) begin
      pin_phase_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_phases.size() == 0) begin
            flag_mismatch("unpredicted phase, data_pins", 10'(rsp_data_pins), 10'd0);
         end else begin
            want = pending_phases.pop_front();
            if (rsp_reg_select !== want.reg_select) begin
               flag_mismatch("reg_select", 10'(rsp_reg_select), 10'(want.reg_select));
            end
            if (rsp_read_write !== want.read_write) begin
               flag_mismatch("read_write", 10'(rsp_read_write), 10'(want.read_write));
            end
            if (rsp_enable !== want.enable) begin
               flag_mismatch("enable", 10'(rsp_enable), 10'(want.enable));
            end
            if (rsp_data_pins !== want.data_pins) begin
               flag_mismatch("data_pins", 10'(rsp_data_pins), 10'(want.data_pins));
            end
            if (rsp_hold_ms !== want.hold_ms) begin
               flag_mismatch("hold_ms", rsp_hold_ms, want.hold_ms);
            end
            if (rsp_last !== want.last) begin
               flag_mismatch("last", 10'(rsp_last), 10'(want.last));
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off when a test asks for it.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            stall_left  = HOLD_OFF_CYCLES;
         end else if (stall_left == 0 && gaps_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_idle_len();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one request, wait for it to be taken, then maybe idle a while.
   task automatic send_request(input action_type act, input logic [7:0] value,
                               input logic [1:0] row, input logic [5:0] column);
      int gap;
      req_valid      <= 1'b1;
      req_action     <= act;
      req_byte_value <= value;
      req_row        <= row;
      req_column     <= column;
      valid_held     = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expand_request(act, value, row, column);
      gap = (gaps_on && $urandom_range(0, 1) == 1) ? pick_idle_len() : 0;
      if (gap > 0) begin
         req_valid  <= 1'b0;
         valid_held = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random_request();
      logic [31:0] r;
      r = $urandom;
      send_request(action_type'(r[1:0]), r[9:2], r[11:10], r[17:12]);
   endtask

   // Stop offering requests and wait until every predicted phase has arrived.
   task automatic wait_drained();
      if (valid_held) begin
         req_valid  <= 1'b0;
         valid_held = 1'b0;
      end
      while (pending_phases.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register; csr_valid stays high for a following write.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_FOUR_BIT_MODE: lcd_cfg.four_bit_mode        = data[0];
         CSR_FUNCTION_SET:  lcd_cfg.function_set_command = data[7:0];
         CSR_DISPLAY_ON:    lcd_cfg.display_on_command   = data[7:0];
         CSR_CLEAR:         lcd_cfg.clear_command        = data[7:0];
         CSR_PHASE_DELAY:   lcd_cfg.phase_delay_ms       = data;
         default: ;
      endcase
   endtask

   // Write all registers; unused upper data bits carry random junk.
   task automatic set_config(input logic mode, input logic [7:0] function_set,
                             input logic [7:0] display_on, input logic [7:0] clear_byte,
                             input logic [9:0] delay);
      logic [31:0] junk;
      junk = $urandom;
      write_reg(CSR_FOUR_BIT_MODE, {junk[8:0], mode});
      write_reg(CSR_FUNCTION_SET, {junk[10:9], function_set});
      write_reg(CSR_DISPLAY_ON, {junk[12:11], display_on});
      write_reg(CSR_CLEAR, {junk[14:13], clear_byte});
      write_reg(CSR_PHASE_DELAY, delay);
      csr_valid <= 1'b0;
   endtask

   // Requests under the register values left by reset.
   task automatic test_reset_defaults();
      send_request(ACT_COMMAND, 8'h00, 2'd0, 6'd0);
      send_request(ACT_DATA, 8'hFF, 2'd3, 6'd63);
      send_request(ACT_INIT, 8'hA5, 2'd1, 6'd21);
      wait_drained();
   endtask

   // Whole-byte bus with extreme bytes, cursor corners and zero hold time.
   task automatic test_eight_bit_bus();
      set_config(1'b0, 8'hFF, 8'h00, 8'hA5, 10'd0);
      send_request(ACT_COMMAND, 8'hFF, 2'd0, 6'd0);
      send_request(ACT_DATA, 8'h00, 2'd0, 6'd0);
      send_request(ACT_DATA, 8'hA5, 2'd0, 6'd0);
      send_request(ACT_CURSOR, 8'hFF, 2'd0, 6'd0);
      send_request(ACT_CURSOR, 8'h00, 2'd3, 6'd63);
      send_request(ACT_CURSOR, 8'h00, 2'd1, 6'd63);
      send_request(ACT_INIT, 8'h00, 2'd2, 6'd5);
      wait_drained();
   endtask

   // Nibble bus: the first phase still shows the byte left from 8-bit mode.
   task automatic test_four_bit_bus();
      set_config(1'b1, 8'h28, 8'h0F, 8'h01, 10'd1023);
      send_request(ACT_DATA, 8'hFF, 2'd0, 6'd0);
      send_request(ACT_COMMAND, 8'h00, 2'd0, 6'd0);
      send_request(ACT_DATA, 8'h5A, 2'd0, 6'd0);
      send_request(ACT_CURSOR, 8'h00, 2'd0, 6'd63);
      send_request(ACT_CURSOR, 8'h00, 2'd1, 6'd0);
      send_request(ACT_CURSOR, 8'h00, 2'd2, 6'd42);
      send_request(ACT_CURSOR, 8'h00, 2'd3, 6'd21);
      send_request(ACT_INIT, 8'h00, 2'd0, 6'd0);
      wait_drained();
   endtask

   // Long receiver hold-off while requests keep coming, so the queue fills.
   task automatic test_input_backpressure();
      gaps_on     = 1'b0;
      hold_off_go = 1'b1;
      for (int i = 0; i < 20; i++) begin
         send_random_request();
      end
      wait_drained();
      gaps_on = 1'b1;
   endtask

   // Random requests over several settings, extremes first, one round unpaced.
   task automatic test_random_traffic();
      logic [31:0] r;
      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         r = $urandom;
         case (round)
            0:       set_config(1'b0, 8'h00, 8'hFF, 8'h00, 10'd0);
            1:       set_config(1'b1, 8'hFF, 8'h00, 8'hFF, 10'd1023);
            default: set_config(r[0], r[8:1], r[16:9], r[24:17], 10'($urandom));
         endcase
         gaps_on = (round != 2);
         for (int i = 0; i < ROUND_REQUESTS; i++) begin
            send_random_request();
         end
         wait_drained();
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      lcd_cfg.four_bit_mode        = 1'b0;
      lcd_cfg.function_set_command = RST_FUNCTION_SET;
      lcd_cfg.display_on_command   = RST_DISPLAY_ON;
      lcd_cfg.clear_command        = RST_CLEAR;
      lcd_cfg.phase_delay_ms       = RST_PHASE_DELAY;
      bus_rs     = 1'b0;
      bus_enable = 1'b0;
      bus_data   = 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_eight_bit_bus();
      test_four_bit_bus();
      test_input_backpressure();
      test_random_traffic();
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #15_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/clcd_pkg.sv
hw/rtl/clcd_csr.sv
hw/rtl/clcd_front.sv
hw/rtl/clcd_queue.sv
hw/rtl/clcd_back.sv
hw/rtl/char_lcd_write_sequencer_core.sv
bench/tb_char_lcd_write_sequencer_core.sv
